// File: hw/rtl/dsdt_s5_sleep_type_scanner_macros.svh
// Assertion macros shared by the _S5_ sleep type scanner RTL.
`ifndef DSDT_S5_SLEEP_TYPE_SCANNER_MACROS_SVH
`define DSDT_S5_SLEEP_TYPE_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSDT_S5_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dsdt_s5 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSDT_S5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsdt_s5 next-cycle check failed");

`endif

// File: hw/rtl/dsdt_s5_pkg.sv
// Types and constants shared by the _S5_ sleep type scanner modules.
`default_nettype none

package dsdt_s5_pkg;

    localparam int unsigned POS_W = 25;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_MAX = {POS_W{1'b1}};

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_SCAN,
        PH_PKGLEN,
        PH_SKIP,
        PH_PREA,
        PH_TYPA,
        PH_AFTA,
        PH_TYPB,
        PH_FOUND,
        PH_STOP
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_NO_S5     = 3'd3,
        ST_SHORT_PKG = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef struct packed {
        t_status    status;
        logic       found;
        logic [7:0] type_a;
        logic [7:0] type_b;
    } t_result;

    // Signature bytes, offset 0 in the lowest lane.
    localparam logic [3:0][7:0] SIG_BYTES = {8'h54, 8'h44, 8'h53, 8'h44};

    localparam logic [7:0] NAME_OP     = 8'h08;
    localparam logic [7:0] PACKAGE_OP  = 8'h12;
    localparam logic [7:0] BYTE_PREFIX = 8'h0A;
    localparam logic [7:0] ROOT_CHAR   = 8'h5C;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_FIVE   = 8'h35;
    localparam logic [7:0] CHAR_S      = 8'h53;

    localparam logic [31:0] MIN_LENGTH = 32'd36;
    localparam t_pos        SCAN_START = t_pos'(40);
    localparam t_pos        NAME_SPAN  = t_pos'(4);

endpackage

`default_nettype wire

// File: hw/rtl/dsdt_s5_parser.sv
// Per-table parsing state: header check, _S5_ search, package walk and status.
`default_nettype none

module dsdt_s5_parser #(
    parameter int unsigned MAX_TABLE_BYTES = 16777216
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire dsdt_s5_pkg::t_word  i_word,
    output dsdt_s5_pkg::t_result     o_result
);

    localparam logic [31:0] MAX_LENGTH = 32'(MAX_TABLE_BYTES);

    logic [5:0][7:0]         r_window;
    logic [5:0][7:0]         n_window;
    dsdt_s5_pkg::t_pos       r_pos;
    dsdt_s5_pkg::t_pos       n_pos;
    logic [31:0]             r_len;
    logic [31:0]             n_len;
    dsdt_s5_pkg::t_phase     r_phase;
    dsdt_s5_pkg::t_phase     n_phase;
    logic [2:0]              r_skip;
    logic [2:0]              n_skip;
    dsdt_s5_pkg::t_pos       r_match;
    dsdt_s5_pkg::t_pos       n_match;
    logic [7:0]              r_type_a;
    logic [7:0]              n_type_a;
    logic [7:0]              r_type_b;
    logic [7:0]              n_type_b;
    dsdt_s5_pkg::t_status    r_outcome;
    dsdt_s5_pkg::t_status    n_outcome;

    logic [7:0]  w_byte;
    logic        w_in_bound;
    logic        w_sig_bad;
    logic [31:0] w_len_full;
    logic        w_len_ok;
    logic        w_hit;
    logic        w_past_end;
    logic [25:0] w_match_end;

    assign w_byte = i_word.data;

    always_comb begin
        w_in_bound = 32'(r_pos) < r_len;
        w_sig_bad  = w_byte != dsdt_s5_pkg::SIG_BYTES[r_pos[1:0]];
        w_len_full = r_len | (32'(w_byte) << {r_pos[1:0], 3'b000});
        w_len_ok   = (w_len_full >= dsdt_s5_pkg::MIN_LENGTH) && (w_len_full <= MAX_LENGTH);
        w_hit      = (r_pos >= dsdt_s5_pkg::SCAN_START)
                     && ((32'(r_pos) + 32'd4) < r_len)
                     && (w_byte == dsdt_s5_pkg::PACKAGE_OP)
                     && (r_window[0] == dsdt_s5_pkg::CHAR_UNDER)
                     && (r_window[1] == dsdt_s5_pkg::CHAR_FIVE)
                     && (r_window[2] == dsdt_s5_pkg::CHAR_S)
                     && (r_window[3] == dsdt_s5_pkg::CHAR_UNDER)
                     && ((r_window[4] == dsdt_s5_pkg::NAME_OP)
                         || ((r_window[5] == dsdt_s5_pkg::NAME_OP)
                             && (r_window[4] == dsdt_s5_pkg::ROOT_CHAR)));
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            dsdt_s5_pkg::PH_HEADER: begin
                if (!r_pos[2]) begin
                    if (w_sig_bad) begin
                        n_phase = dsdt_s5_pkg::PH_STOP;
                    end
                end else if (r_pos[1:0] == 2'd3) begin
                    n_phase = w_len_ok ? dsdt_s5_pkg::PH_SCAN : dsdt_s5_pkg::PH_STOP;
                end
            end
            dsdt_s5_pkg::PH_SCAN: begin
                if (w_in_bound && w_hit) begin
                    n_phase = dsdt_s5_pkg::PH_PKGLEN;
                end
            end
            dsdt_s5_pkg::PH_PKGLEN: begin
                if (w_in_bound) begin
                    n_phase = dsdt_s5_pkg::PH_SKIP;
                end
            end
            dsdt_s5_pkg::PH_SKIP: begin
                if (w_in_bound && (3'(r_skip - 3'd1) == 3'd0)) begin
                    n_phase = dsdt_s5_pkg::PH_PREA;
                end
            end
            dsdt_s5_pkg::PH_PREA: begin
                if (w_in_bound) begin
                    n_phase = (w_byte == dsdt_s5_pkg::BYTE_PREFIX) ? dsdt_s5_pkg::PH_TYPA
                                                                   : dsdt_s5_pkg::PH_AFTA;
                end
            end
            dsdt_s5_pkg::PH_TYPA: begin
                if (w_in_bound) begin
                    n_phase = dsdt_s5_pkg::PH_AFTA;
                end
            end
            dsdt_s5_pkg::PH_AFTA: begin
                if (w_in_bound) begin
                    n_phase = (w_byte == dsdt_s5_pkg::BYTE_PREFIX) ? dsdt_s5_pkg::PH_TYPB
                                                                   : dsdt_s5_pkg::PH_FOUND;
                end
            end
            dsdt_s5_pkg::PH_TYPB: begin
                if (w_in_bound) begin
                    n_phase = dsdt_s5_pkg::PH_FOUND;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        n_window  = {r_window[4:0], w_byte};
        n_pos     = (r_pos == dsdt_s5_pkg::POS_MAX) ? r_pos : r_pos + dsdt_s5_pkg::t_pos'(1);
        n_len     = r_len;
        n_skip    = r_skip;
        n_match   = r_match;
        n_type_a  = r_type_a;
        n_type_b  = r_type_b;
        n_outcome = r_outcome;
        if (r_phase == dsdt_s5_pkg::PH_HEADER) begin
            if (!r_pos[2]) begin
                if (w_sig_bad) begin
                    n_outcome = dsdt_s5_pkg::ST_BAD_SIG;
                end
            end else begin
                n_len = w_len_full;
                if ((r_pos[1:0] == 2'd3) && !w_len_ok) begin
                    n_outcome = dsdt_s5_pkg::ST_BAD_LEN;
                end
            end
        end else if (w_in_bound) begin
            case (r_phase)
                dsdt_s5_pkg::PH_SCAN: begin
                    if (w_hit) begin
                        n_match = r_pos - dsdt_s5_pkg::NAME_SPAN;
                    end
                end
                dsdt_s5_pkg::PH_PKGLEN: begin
                    n_skip = {1'b0, w_byte[7:6]} + 3'd1;
                end
                dsdt_s5_pkg::PH_SKIP: begin
                    n_skip = r_skip - 3'd1;
                end
                dsdt_s5_pkg::PH_PREA: begin
                    if (w_byte != dsdt_s5_pkg::BYTE_PREFIX) begin
                        n_type_a = w_byte;
                    end
                end
                dsdt_s5_pkg::PH_TYPA: begin
                    n_type_a = w_byte;
                end
                dsdt_s5_pkg::PH_AFTA: begin
                    if (w_byte != dsdt_s5_pkg::BYTE_PREFIX) begin
                        n_type_b = w_byte;
                    end
                end
                dsdt_s5_pkg::PH_TYPB: begin
                    n_type_b = w_byte;
                end
                default: begin
                    n_skip = r_skip;
                end
            endcase
        end
    end

    // The status is formed from the state as it stands after this word.
    always_comb begin
        w_match_end = {1'b0, n_match} + 26'd8;
        w_past_end  = (w_match_end > {1'b0, r_pos}) || (32'(w_match_end) >= n_len);
        o_result        = '0;
        o_result.type_a = n_type_a;
        o_result.type_b = n_type_b;
        case (n_phase)
            dsdt_s5_pkg::PH_HEADER: begin
                o_result.status = (r_pos < dsdt_s5_pkg::t_pos'(3)) ? dsdt_s5_pkg::ST_BAD_SIG
                                                                   : dsdt_s5_pkg::ST_BAD_LEN;
            end
            dsdt_s5_pkg::PH_STOP: begin
                o_result.status = n_outcome;
            end
            dsdt_s5_pkg::PH_PKGLEN, dsdt_s5_pkg::PH_SKIP, dsdt_s5_pkg::PH_PREA,
            dsdt_s5_pkg::PH_TYPA: begin
                o_result.status = w_past_end ? dsdt_s5_pkg::ST_NO_S5
                                             : dsdt_s5_pkg::ST_SHORT_PKG;
            end
            dsdt_s5_pkg::PH_AFTA, dsdt_s5_pkg::PH_TYPB, dsdt_s5_pkg::PH_FOUND: begin
                o_result.status = w_past_end ? dsdt_s5_pkg::ST_NO_S5 : dsdt_s5_pkg::ST_FOUND;
                o_result.found  = !w_past_end;
            end
            default: begin
                o_result.status = dsdt_s5_pkg::ST_NO_S5;
            end
        endcase
        if (!o_result.found) begin
            o_result.type_a = 8'd0;
            o_result.type_b = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last)) begin
            r_window  <= '0;
            r_pos     <= '0;
            r_len     <= '0;
            r_phase   <= dsdt_s5_pkg::PH_HEADER;
            r_skip    <= '0;
            r_match   <= '0;
            r_type_a  <= '0;
            r_type_b  <= '0;
            r_outcome <= dsdt_s5_pkg::ST_NO_S5;
        end else if (i_step) begin
            r_window  <= n_window;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_match   <= n_match;
            r_type_a  <= n_type_a;
            r_type_b  <= n_type_b;
            r_outcome <= n_outcome;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dsdt_s5_sleep_type_scanner.sv
// Top level of the DSDT _S5_ sleep type scanner with its input and result registers.
// Throughput: one table byte per cycle; a word is taken while a result waits.
// The word that ends the table passes the input register; its result is then registered and marked valid.
// Only the word that ends the table waits when the result register is still full.
// Reset empties the input and result registers and returns the parser to the header check.
`default_nettype none
`include "dsdt_s5_sleep_type_scanner_macros.svh"

module dsdt_s5_sleep_type_scanner #(
    parameter int unsigned MAX_TABLE_BYTES = 16777216
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_table_byte,
    input  wire logic               i_end_of_table,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_scan_status,
    output logic [7:0]              o_sleep_type_a,
    output logic [7:0]              o_sleep_type_b,
    output logic signed [16:0]      o_packed_values
);

    logic                  r_in_valid;
    dsdt_s5_pkg::t_word    r_in_word;
    logic                  r_out_valid;
    dsdt_s5_pkg::t_status  r_out_status;
    logic [7:0]            r_out_type_a;
    logic [7:0]            r_out_type_b;
    logic signed [16:0]    r_out_packed;

    logic                  w_advance;
    logic                  w_step;
    dsdt_s5_pkg::t_result  w_result;

    assign w_advance = !r_in_word.last || !r_out_valid || i_ready;
    assign w_step    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    dsdt_s5_parser #(
        .MAX_TABLE_BYTES(MAX_TABLE_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (r_in_word),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_word.data <= i_table_byte;
            r_in_word.last <= i_end_of_table;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_word.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_word.last) begin
            r_out_status <= w_result.status;
            r_out_type_a <= w_result.type_a;
            r_out_type_b <= w_result.type_b;
            r_out_packed <= w_result.found ? $signed({1'b0, w_result.type_b, w_result.type_a})
                                           : {17{1'b1}};
        end
    end

    assign o_valid         = r_out_valid;
    assign o_scan_status   = r_out_status;
    assign o_sleep_type_a  = r_out_type_a;
    assign o_sleep_type_b  = r_out_type_b;
    assign o_packed_values = r_out_packed;

    `DSDT_S5_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, o_ready)
    `DSDT_S5_ASSERT_SAME(a_last_waits_on_full, i_clk, i_rst_n,
        r_in_valid && r_in_word.last && r_out_valid && !i_ready, !o_ready)
    `DSDT_S5_ASSERT_SAME(a_found_packs_types, i_clk, i_rst_n,
        r_out_valid && (r_out_status == dsdt_s5_pkg::ST_FOUND),
        r_out_packed == $signed({1'b0, r_out_type_b, r_out_type_a}))
    `DSDT_S5_ASSERT_SAME(a_miss_clears_types, i_clk, i_rst_n,
        r_out_valid && (r_out_status != dsdt_s5_pkg::ST_FOUND),
        (r_out_type_a == 8'd0) && (r_out_type_b == 8'd0) && (r_out_packed == -17'sd1))
    `DSDT_S5_ASSERT_NEXT(a_last_loads_result, i_clk, i_rst_n,
        w_step && r_in_word.last, r_out_valid)

endmodule

`default_nettype wire
